>>> hw/rtl/atp_pkg.sv
// shared types, codes and constants of the trapezoid motion profile axis
`timescale 1ns / 1ps

package atp_pkg;

  // field widths
  localparam int unsigned ModeW  = 2;
  localparam int unsigned PosW   = 32;
  localparam int unsigned VelW   = 31;
  localparam int unsigned AccW   = 31;
  localparam int unsigned TickW  = 21;
  localparam int unsigned OpW    = 2;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdxW = 3;

  // tick period is in units of 2^-20 s
  localparam int unsigned TickShift = 20;

  // register reset values
  localparam logic [ModeW-1:0] ModeRst   = 2'd0;
  localparam logic [PosW-1:0]  MinPosRst = 32'd0;
  localparam logic [PosW-1:0]  MaxPosRst = 32'd0;
  localparam logic [VelW-1:0]  MaxVelRst = 31'd6553600;
  localparam logic [AccW-1:0]  AccelRst  = 31'd13107200;
  localparam logic [TickW-1:0] TickRst   = 21'd1049;

  // speed above this counts as moving (0.001 units/s)
  localparam logic [31:0] MoveThreshold = 32'd65;

  // command codes
  localparam logic [OpW-1:0] OP_TICK       = 2'd0;
  localparam logic [OpW-1:0] OP_SET_TARGET = 2'd1;
  localparam logic [OpW-1:0] OP_STOP       = 2'd2;
  localparam logic [OpW-1:0] OP_FORCE_POS  = 2'd3;

  // axis modes
  localparam logic [ModeW-1:0] MODE_POSITION = 2'd0;
  localparam logic [ModeW-1:0] MODE_VELOCITY = 2'd1;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_AXIS_MODE    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_MIN_POSITION = 3'd1;
  localparam logic [RegIdxW-1:0] REG_MAX_POSITION = 3'd2;
  localparam logic [RegIdxW-1:0] REG_MAX_VELOCITY = 3'd3;
  localparam logic [RegIdxW-1:0] REG_ACCELERATION = 3'd4;
  localparam logic [RegIdxW-1:0] REG_TICK_PERIOD  = 3'd5;

  typedef struct packed {
    logic [ModeW-1:0] axis_mode;
    logic [PosW-1:0]  min_position;
    logic [PosW-1:0]  max_position;
    logic [VelW-1:0]  max_velocity;
    logic [AccW-1:0]  acceleration;
    logic [TickW-1:0] tick_period;
  } cfg_t;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_APPLY,
    CMD_MUL_VV,
    CMD_MUL_DA,
    CMD_MUL_AT,
    CMD_VEL,
    CMD_MUL_DS,
    CMD_POS,
    CMD_CLAMP,
    CMD_LOAD_OUT
  } dp_cmd_e;

  typedef struct packed {
    logic is_tick;
    logic tick_zero;
    logic pos_move;
    logic vel_mode;
  } dp_status_t;

endpackage

>>> hw/rtl/atp_regs.sv
// configuration register file behind the apb port
`timescale 1ns / 1ps

module atp_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [atp_pkg::AddrW-1:0]    paddr,
  input  logic [atp_pkg::DataW-1:0]    pwdata,
  output logic [atp_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output atp_pkg::cfg_t                cfg_o
);

  atp_pkg::cfg_t                   cfg_q, cfg_d;
  logic                            wr_en;
  logic [atp_pkg::RegIdxW-1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[atp_pkg::AddrW-1:2];
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        atp_pkg::REG_AXIS_MODE:    cfg_d.axis_mode    = pwdata[atp_pkg::ModeW-1:0];
        atp_pkg::REG_MIN_POSITION: cfg_d.min_position = pwdata[atp_pkg::PosW-1:0];
        atp_pkg::REG_MAX_POSITION: cfg_d.max_position = pwdata[atp_pkg::PosW-1:0];
        atp_pkg::REG_MAX_VELOCITY: cfg_d.max_velocity = pwdata[atp_pkg::VelW-1:0];
        atp_pkg::REG_ACCELERATION: cfg_d.acceleration = pwdata[atp_pkg::AccW-1:0];
        atp_pkg::REG_TICK_PERIOD:  cfg_d.tick_period  = pwdata[atp_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      atp_pkg::REG_AXIS_MODE:    prdata = {30'd0, cfg_q.axis_mode};
      atp_pkg::REG_MIN_POSITION: prdata = cfg_q.min_position;
      atp_pkg::REG_MAX_POSITION: prdata = cfg_q.max_position;
      atp_pkg::REG_MAX_VELOCITY: prdata = {1'b0, cfg_q.max_velocity};
      atp_pkg::REG_ACCELERATION: prdata = {1'b0, cfg_q.acceleration};
      atp_pkg::REG_TICK_PERIOD:  prdata = {11'd0, cfg_q.tick_period};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_mode    <= atp_pkg::ModeRst;
      cfg_q.min_position <= atp_pkg::MinPosRst;
      cfg_q.max_position <= atp_pkg::MaxPosRst;
      cfg_q.max_velocity <= atp_pkg::MaxVelRst;
      cfg_q.acceleration <= atp_pkg::AccelRst;
      cfg_q.tick_period  <= atp_pkg::TickRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hw/rtl/atp_ctrl.sv
// controller state machine sequencing one command through the datapath
`timescale 1ns / 1ps

module atp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  atp_pkg::dp_status_t  status_i,
  output atp_pkg::dp_cmd_e     cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_MUL_VV   = 4'd2;
  localparam logic [3:0] S_MUL_DA   = 4'd3;
  localparam logic [3:0] S_MUL_AT   = 4'd4;
  localparam logic [3:0] S_VEL      = 4'd5;
  localparam logic [3:0] S_MUL_DS   = 4'd6;
  localparam logic [3:0] S_POS      = 4'd7;
  localparam logic [3:0] S_CLAMP    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = atp_pkg::CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = atp_pkg::CMD_LATCH;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!status_i.is_tick) begin
          cmd_o   = atp_pkg::CMD_APPLY;
          state_d = S_DONE;
        end else if (status_i.tick_zero) begin
          state_d = S_DONE;
        end else if (status_i.pos_move) begin
          state_d = S_MUL_VV;
        end else if (status_i.vel_mode) begin
          state_d = S_MUL_DS;
        end else begin
          state_d = S_CLAMP;
        end
      end
      S_MUL_VV: begin
        cmd_o   = atp_pkg::CMD_MUL_VV;
        state_d = S_MUL_DA;
      end
      S_MUL_DA: begin
        cmd_o   = atp_pkg::CMD_MUL_DA;
        state_d = S_MUL_AT;
      end
      S_MUL_AT: begin
        cmd_o   = atp_pkg::CMD_MUL_AT;
        state_d = S_VEL;
      end
      S_VEL: begin
        cmd_o   = atp_pkg::CMD_VEL;
        state_d = S_MUL_DS;
      end
      S_MUL_DS: begin
        cmd_o   = atp_pkg::CMD_MUL_DS;
        state_d = S_POS;
      end
      S_POS: begin
        cmd_o   = atp_pkg::CMD_POS;
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o   = atp_pkg::CMD_CLAMP;
        state_d = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd_o   = atp_pkg::CMD_LOAD_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o == atp_pkg::CMD_LOAD_OUT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hw/rtl/atp_dp.sv
// datapath: axis state, shared multiplier, velocity and position update, output word
`timescale 1ns / 1ps

module atp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  atp_pkg::dp_cmd_e              cmd_i,
  input  atp_pkg::cfg_t                 cfg_i,
  input  logic [atp_pkg::OpW-1:0]       opcode_i,
  input  logic signed [31:0]            operand_value_i,
  output atp_pkg::dp_status_t           status_o,
  output logic signed [31:0]            actual_position_o,
  output logic signed [31:0]            actual_velocity_o,
  output logic                          moving_o,
  output logic                          at_rest_o
);

  // axis state
  logic signed [31:0]          pos_q, pos_d;
  logic signed [31:0]          vel_q, vel_d;
  logic signed [31:0]          goal_q, goal_d;
  logic                        flag_q, flag_d;

  // latched command
  logic [atp_pkg::OpW-1:0]     op_q;
  logic signed [31:0]          val_q;

  // multiplier and intermediate products
  logic [32:0]                 mul_a;
  logic [31:0]                 mul_b;
  logic [64:0]                 product;
  logic [64:0]                 prod_q;
  logic [64:0]                 vv_q;
  logic                        brake_q;

  // output word
  logic signed [31:0]          out_pos_q;
  logic signed [31:0]          out_vel_q;
  logic                        out_moving_q;

  logic signed [32:0]          diff;
  logic [32:0]                 dist_mag;
  logic                        dir_pos;
  logic [31:0]                 vmag;
  logic                        moving_now;
  logic                        pos_mode;

  logic [31:0]                 step_mag;
  logic [32:0]                 maxv_ext;
  logic signed [32:0]          tv;
  logic signed [33:0]          err;
  logic [33:0]                 err_mag;
  logic                        err_pos;
  logic signed [34:0]          vstep;
  logic signed [31:0]          vel_upd;

  logic                        snap;
  logic signed [34:0]          pstep;
  logic signed [31:0]          pos_step;

  logic signed [31:0]          min_s;
  logic signed [31:0]          max_s;
  logic signed [31:0]          clamp_hi;
  logic signed [31:0]          clamp_pos;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  assign pos_mode = (cfg_i.axis_mode == atp_pkg::MODE_POSITION);

  assign diff     = {goal_q[31], goal_q} - {pos_q[31], pos_q};
  assign dist_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign dir_pos  = !diff[32] && (diff != 33'sd0);
  assign vmag     = vel_q[31] ? 32'(-vel_q) : 32'(vel_q);
  assign moving_now = flag_q || (vmag > atp_pkg::MoveThreshold);

  assign status_o.is_tick   = (op_q == atp_pkg::OP_TICK);
  assign status_o.tick_zero = (cfg_i.tick_period == '0);
  assign status_o.pos_move  = pos_mode && flag_q;
  assign status_o.vel_mode  = (cfg_i.axis_mode == atp_pkg::MODE_VELOCITY);

  // one shared multiplier, operands picked per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i)
      atp_pkg::CMD_MUL_VV: begin
        mul_a = {1'b0, vmag};
        mul_b = vmag;
      end
      atp_pkg::CMD_MUL_DA: begin
        mul_a = dist_mag;
        mul_b = {1'b0, cfg_i.acceleration};
      end
      atp_pkg::CMD_MUL_AT: begin
        mul_a = {2'b00, cfg_i.acceleration};
        mul_b = {11'd0, cfg_i.tick_period};
      end
      atp_pkg::CMD_MUL_DS: begin
        mul_a = {1'b0, vmag};
        mul_b = {11'd0, cfg_i.tick_period};
      end
      default: ;
    endcase
  end

  assign product = {32'd0, mul_a} * {33'd0, mul_b};

  // scaled product: dv after the a*t step, |ds| after the v*t step
  assign step_mag = prod_q[atp_pkg::TickShift+31:atp_pkg::TickShift];

  // velocity step toward the target speed
  assign maxv_ext = {2'b00, cfg_i.max_velocity};
  assign tv       = brake_q ? 33'sd0 : (dir_pos ? $signed(maxv_ext) : $signed(-maxv_ext));
  assign err      = {tv[32], tv} - {{2{vel_q[31]}}, vel_q};
  assign err_mag  = err[33] ? 34'(-err) : 34'(err);
  assign err_pos  = !err[33] && (err != 34'sd0);
  assign vstep    = err_pos ? ({{3{vel_q[31]}}, vel_q} + {3'b000, step_mag})
                            : ({{3{vel_q[31]}}, vel_q} - {3'b000, step_mag});
  assign vel_upd  = (err_mag < {2'b00, step_mag}) ? tv[31:0] : sat32(vstep);

  // position step with the sign of the velocity
  assign snap     = ({1'b0, step_mag} >= dist_mag);
  assign pstep    = vel_q[31] ? ({{3{pos_q[31]}}, pos_q} - {3'b000, step_mag})
                              : ({{3{pos_q[31]}}, pos_q} + {3'b000, step_mag});
  assign pos_step = sat32(pstep);

  // limit clamp, inverted limits end at min_position
  assign min_s     = cfg_i.min_position;
  assign max_s     = cfg_i.max_position;
  assign clamp_hi  = (pos_q < max_s) ? pos_q : max_s;
  assign clamp_pos = (clamp_hi > min_s) ? clamp_hi : min_s;

  always_comb begin
    pos_d  = pos_q;
    vel_d  = vel_q;
    goal_d = goal_q;
    flag_d = flag_q;
    unique case (cmd_i)
      atp_pkg::CMD_APPLY: begin
        case (op_q)
          atp_pkg::OP_SET_TARGET: begin
            if (pos_mode) begin
              goal_d = val_q;
              flag_d = 1'b1;
            end else if (status_o.vel_mode) begin
              vel_d = val_q;
            end
          end
          atp_pkg::OP_STOP: begin
            if (pos_mode) begin
              goal_d = pos_q;
            end else begin
              vel_d = '0;
            end
            flag_d = 1'b0;
          end
          atp_pkg::OP_FORCE_POS: begin
            pos_d  = val_q;
            goal_d = val_q;
            flag_d = 1'b0;
          end
          default: ;
        endcase
      end
      atp_pkg::CMD_VEL: vel_d = vel_upd;
      atp_pkg::CMD_POS: begin
        if (pos_mode) begin
          if (snap) begin
            pos_d  = goal_q;
            vel_d  = '0;
            flag_d = 1'b0;
          end else begin
            pos_d = pos_step;
          end
        end else begin
          pos_d  = pos_step;
          flag_d = (vmag > atp_pkg::MoveThreshold);
        end
      end
      atp_pkg::CMD_CLAMP: begin
        if (min_s != max_s) begin
          pos_d = clamp_pos;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      vel_q  <= '0;
      goal_q <= '0;
      flag_q <= 1'b0;
      op_q   <= atp_pkg::OP_TICK;
    end else begin
      pos_q  <= pos_d;
      vel_q  <= vel_d;
      goal_q <= goal_d;
      flag_q <= flag_d;
      if (cmd_i == atp_pkg::CMD_LATCH) begin
        op_q <= opcode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == atp_pkg::CMD_LATCH) begin
      val_q <= operand_value_i;
    end
    if (cmd_i == atp_pkg::CMD_MUL_VV || cmd_i == atp_pkg::CMD_MUL_DA ||
        cmd_i == atp_pkg::CMD_MUL_AT || cmd_i == atp_pkg::CMD_MUL_DS) begin
      prod_q <= product;
    end
    if (cmd_i == atp_pkg::CMD_MUL_DA) begin
      vv_q <= prod_q;
    end
    // brake when 2*a*distance <= v*v, same as distance <= floor(v*v / 2a)
    if (cmd_i == atp_pkg::CMD_MUL_AT) begin
      brake_q <= ({prod_q, 1'b0} <= {1'b0, vv_q});
    end
    if (cmd_i == atp_pkg::CMD_LOAD_OUT) begin
      out_pos_q    <= pos_q;
      out_vel_q    <= vel_q;
      out_moving_q <= moving_now;
    end
  end

  assign actual_position_o = out_pos_q;
  assign actual_velocity_o = out_vel_q;
  assign moving_o          = out_moving_q;
  assign at_rest_o         = !out_moving_q;

endmodule

>>> hw/rtl/axis_trapezoid_profile.sv
// top level of the single-axis trapezoid motion profile generator
//
//  channel   direction  handshake                  payload
//  in        in         in_valid_i / in_ready_o    opcode_i, operand_value_i
//  out       out        out_valid_o / out_ready_i  actual_position_o, actual_velocity_o,
//                                                  moving_o, at_rest_o
//  config    in         apb psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// set target, stop and force apply directly; a velocity-mode tick runs the v*t,
// position and clamp steps, a moving position-mode tick also updates velocity; the four
// dependent products go one after another through the single 33x32 multiplier.
// a new word is taken once the previous result sits in the output register.
// reset clears the axis state and loads the register defaults.
// a stalled output holds the controller in its last step until the word is taken.
`timescale 1ns / 1ps

module axis_trapezoid_profile (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [atp_pkg::OpW-1:0]     opcode_i,
  input  logic signed [31:0]          operand_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          actual_position_o,
  output logic signed [31:0]          actual_velocity_o,
  output logic                        moving_o,
  output logic                        at_rest_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [atp_pkg::AddrW-1:0]   paddr,
  input  logic [atp_pkg::DataW-1:0]   pwdata,
  output logic [atp_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  atp_pkg::cfg_t        cfg;
  atp_pkg::dp_cmd_e     cmd;
  atp_pkg::dp_status_t  status;

  atp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  atp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  atp_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_i             (cfg),
    .opcode_i          (opcode_i),
    .operand_value_i   (operand_value_i),
    .status_o          (status),
    .actual_position_o (actual_position_o),
    .actual_velocity_o (actual_velocity_o),
    .moving_o          (moving_o),
    .at_rest_o         (at_rest_o)
  );

endmodule
